[hw/rtl/fqmq_pkg.sv]
// Shared constants, codes and types of the FIFO queue with maximum query.
package fqmq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int OP_W = 2;
   localparam int ST_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_ENQ = OP_W'(0);
   localparam logic [OP_W-1:0] OP_DEQ = OP_W'(1);
   localparam logic [OP_W-1:0] OP_MAX = OP_W'(2);

   localparam logic [ST_W-1:0] ST_OK    = ST_W'(0);
   localparam logic [ST_W-1:0] ST_EMPTY = ST_W'(1);
   localparam logic [ST_W-1:0] ST_FULL  = ST_W'(2);

   typedef enum logic [1:0] {
      CMD_ENQ,
      CMD_DEQ,
      CMD_MAX,
      CMD_NOP
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic signed [VAL_W-1:0]  value;
   } cmd_type;

endpackage

[hw/rtl/fqmq_if.sv]
// Valid/ready channel interfaces for the request and response words.
interface fqmq_req_if import fqmq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic signed [VAL_W-1:0] push_value;

   modport source (output valid, opcode, push_value, input ready);
   modport sink   (input valid, opcode, push_value, output ready);
endinterface

interface fqmq_rsp_if import fqmq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] result_value;
   logic [ST_W-1:0]         status;

   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

[hw/rtl/fqmq_front.sv]
// Front end: takes request words and decodes the opcode into a command.
module fqmq_front import fqmq_pkg::*; (
   fqmq_req_if.sink req_ch,
   output logic     push_valid,
   input  logic     push_ready,
   output cmd_type  push_cmd
);

   assign push_valid = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_cmd.value = req_ch.push_value;
      case (req_ch.opcode)
         OP_ENQ:  push_cmd.kind = CMD_ENQ;
         OP_DEQ:  push_cmd.kind = CMD_DEQ;
         OP_MAX:  push_cmd.kind = CMD_MAX;
         default: push_cmd.kind = CMD_NOP;
      endcase
   end

endmodule

[hw/rtl/fqmq_cmd_queue.sv]
// Short command queue that decouples the front end from the execution unit.
module fqmq_cmd_queue import fqmq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int Q_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [Q_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != Q_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hw/rtl/fqmq_back.sv]
// Execution unit: entry memory, head/tail/count, maximum scan and response register.
module fqmq_back import fqmq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   fqmq_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DEQ  = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   logic signed [VAL_W-1:0] mem [DEPTH];

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        issued_ff, issued_in;
   logic                    first_ff, first_in;
   logic signed [VAL_W-1:0] max_ff, max_in;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ST_W-1:0]         rsp_status_ff, rsp_status_in;

   logic                    out_free, take;
   logic                    wr_en, rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic signed [VAL_W-1:0] cand;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = (state_ff == S_IDLE) && out_free;
   assign take      = pop_valid && pop_ready;
   assign cand      = (first_ff || (rd_data_ff > max_ff)) ? rd_data_ff : max_ff;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      issued_in     = issued_ff;
      first_in      = first_ff;
      max_in        = max_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (pop_cmd.kind)
                  CMD_ENQ: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_OK;
                        wr_en    = 1'b1;
                        tail_in  = next_idx(tail_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_DEQ;
                     end
                  end
                  CMD_MAX: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_ptr_in = next_idx(head_ff);
                        issued_in = CNT_W'(1);
                        first_in  = 1'b1;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_DEQ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_data_ff;
            rsp_status_in = ST_OK;
            head_in       = next_idx(head_ff);
            count_in      = count_ff - 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            max_in   = cand;
            first_in = 1'b0;
            if (issued_ff == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = cand;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = rd_ptr_ff;
               rd_ptr_in = next_idx(rd_ptr_ff);
               issued_in = issued_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      issued_ff     <= issued_in;
      first_ff      <= first_in;
      max_ff        <= max_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= pop_cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds the queue depth");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !rsp_valid_ff)
      else $error("response pending while a command is in progress");

   a_ptr_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> head_ff == tail_ff)
      else $error("head and tail disagree for an empty or full queue");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> (issued_ff != '0 && issued_ff <= count_ff))
      else $error("maximum scan has read outside the held entries");

endmodule

[hw/rtl/fifo_queue_with_max_query.sv]
// Top level of the bounded FIFO queue of signed words with a maximum query.
//
// The block holds up to DEPTH (16) signed 32-bit words in first-in, first-out
// order. Every request word carries an opcode and a value and produces exactly
// one response word with a value and a status: enqueue answers ok, or full when
// the queue already holds DEPTH words; dequeue returns the oldest word, or
// reports empty; find-max returns the largest held word by signed comparison
// without disturbing the contents, or reports empty; the unused opcode is
// answered ok with a zero value. The result value is zero whenever no word is
// returned. Requests are decoded by a front end into a two-deep command queue,
// so up to two further requests are taken while the execution unit is busy or
// its response word is still waiting to be taken. The execution unit works on
// one command at a time: enqueue, the unused opcode and any error answer are
// answered straight from the idle state; a dequeue waits in a read state for
// the single registered read port of the entry memory; a find-max walks the
// held words through that port in a scan state, one entry per cycle. After
// reset the queue is empty and ready at once; no clearing pass is needed.
module fifo_queue_with_max_query import fqmq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fqmq_req_if.sink   req_ch,
   fqmq_rsp_if.source rsp_ch
);

   // Decoded commands travel from the front end through the command queue.
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   fqmq_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   fqmq_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // The execution unit owns the entry memory and the response register.
   fqmq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

[tb/tb.sv]
// Self-checking testbench of the FIFO queue with maximum query.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fqmq_pkg::*;

   // Sizes of the run. The random part follows a short directed opening.
   localparam int RANDOM_WORDS = 1900;
   localparam int IDLE_PERCENT = 25;
   localparam int CALM_FIRST   = 700;   // request words sent before the calm stretch
   localparam int CALM_LAST    = 1000;  // request words sent when it ends
   localparam int HOLD_AFTER   = 1300;  // response words taken before the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;    // wait after the last answer for stray response words
   localparam int CYCLE_LIMIT  = 400000;

   // One expected response word.
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [ST_W-1:0]         status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fqmq_req_if req_bus ();
   fqmq_rsp_if rsp_bus ();

   fifo_queue_with_max_query u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #5ns clock = ~clock;

   // Commands still to be offered, and the answers the queue owes us, oldest first.
   cmd_type    stimulus [$];
   answer_type awaited [$];
   cmd_type    on_offer;

   // Our own copy of the queue contents, used to work out every answer.
   logic signed [VAL_W-1:0] shadow_store [DEPTH];
   logic [IDX_W-1:0]        shadow_head  = '0;
   logic [IDX_W-1:0]        shadow_tail  = '0;
   logic [CNT_W-1:0]        shadow_count = '0;

   int          words_sent    = 0;
   int          answers_taken = 0;
   int          mismatches    = 0;
   int          total_words   = 0;
   int          hold_left     = 0;
   bit          hold_done     = 1'b0;
   int unsigned cycle_count   = 0;
   logic        calm_stretch;

   // Neither side idles while the calm stretch lasts, so the queue runs flat out.
   assign calm_stretch = (words_sent >= CALM_FIRST) && (words_sent < CALM_LAST);

   // Applies one accepted command to the shadow queue and returns the answer it earns.
   // Slots wrap explicitly so that the model holds for any DEPTH, not only powers of two.
   function automatic answer_type shadow_apply(cmd_type cmd);
      answer_type              ans;
      logic [IDX_W-1:0]        slot;
      logic signed [VAL_W-1:0] best;
      ans.value  = '0;
      ans.status = ST_OK;
      case (cmd.kind)
         CMD_ENQ: begin
            if (shadow_count == CNT_W'(DEPTH)) begin
               ans.status = ST_FULL;
            end else begin
               shadow_store[shadow_tail] = cmd.value;
               shadow_tail  = (shadow_tail == IDX_W'(DEPTH - 1)) ? '0 : shadow_tail + 1'b1;
               shadow_count = shadow_count + 1'b1;
            end
         end
         CMD_DEQ: begin
            if (shadow_count == '0) begin
               ans.status = ST_EMPTY;
            end else begin
               ans.value    = shadow_store[shadow_head];
               shadow_head  = (shadow_head == IDX_W'(DEPTH - 1)) ? '0 : shadow_head + 1'b1;
               shadow_count = shadow_count - 1'b1;
            end
         end
         CMD_MAX: begin
            if (shadow_count == '0) begin
               ans.status = ST_EMPTY;
            end else begin
               // Walk the held words from the oldest, keeping the largest by signed order.
               slot = shadow_head;
               best = shadow_store[slot];
               for (int i = 1; i < int'(shadow_count); i++) begin
                  slot = (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
                  if (shadow_store[slot] > best) begin
                     best = shadow_store[slot];
                  end
               end
               ans.value = best;
            end
         end
         default: begin
            // The unused opcode leaves everything alone and answers ok with zero.
         end
      endcase
      return ans;
   endfunction

   function automatic void queue_cmd(kind_type kind, logic signed [VAL_W-1:0] value);
      cmd_type cmd;
      cmd.kind  = kind;
      cmd.value = value;
      stimulus.push_back(cmd);
   endfunction

   // Request side. A word is taken at an edge with valid and ready both high; the
   // answer it earns is worked out there and then. A fresh word is offered only once
   // the previous one has gone, so valid never drops under a waiting word.
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited.push_back(shadow_apply(on_offer));
            words_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (stimulus.size() != 0
                && (calm_stretch || $urandom_range(99) >= IDLE_PERCENT)) begin
               on_offer = stimulus.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.opcode     <= on_offer.kind;
               req_bus.push_value <= on_offer.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response side. Every word taken is compared with the oldest answer owed. Once,
   // well into the run, ready is held low for a long stretch while requests keep
   // coming, so that the command queue fills and the block pushes back on its input.
   always @(posedge clock) begin : response_monitor
      answer_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            answers_taken++;
            if (awaited.size() == 0) begin
               $error("response word with nothing owed: result_value %0d, status %0d",
                      rsp_bus.result_value, rsp_bus.status);
               mismatches++;
            end else begin
               want = awaited.pop_front();
               if (rsp_bus.result_value !== want.value) begin
                  $error("result_value: expected %0d, got %0d",
                         want.value, rsp_bus.result_value);
                  mismatches++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  mismatches++;
               end
            end
         end
         if (!hold_done && answers_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   initial begin : stimulus_and_end
      int                      enq_weight;
      int                      pick;
      logic signed [VAL_W-1:0] value;

      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_ENQ;
      req_bus.push_value = '0;
      rsp_bus.ready      = 1'b0;

      // Directed opening: both empty errors, the unused opcode with a non-zero value,
      // the signed extremes, a completely full queue, an enqueue refused as full, and
      // a maximum taken over a full queue and again after the oldest words have left.
      queue_cmd(CMD_DEQ, 32'sh0);
      queue_cmd(CMD_MAX, 32'sh7FFF_FFFF);
      queue_cmd(CMD_NOP, 32'sh1234_5678);
      queue_cmd(CMD_ENQ, 32'sh8000_0000);
      queue_cmd(CMD_MAX, 32'sh0);
      queue_cmd(CMD_ENQ, 32'sh7FFF_FFFF);
      queue_cmd(CMD_ENQ, 32'sh0);
      queue_cmd(CMD_ENQ, -32'sd1);
      for (int i = 4; i < DEPTH; i++) begin
         queue_cmd(CMD_ENQ, $urandom());
      end
      queue_cmd(CMD_ENQ, 32'sh5555_5555);
      queue_cmd(CMD_MAX, 32'sh0);
      queue_cmd(CMD_DEQ, 32'sh0);
      queue_cmd(CMD_DEQ, 32'sh0);
      queue_cmd(CMD_MAX, 32'sh0);

      // Random part. The mix leans towards enqueue or towards removal in runs of forty
      // words, so the queue keeps swinging between full and empty. Values come from
      // the whole range, from a narrow band around zero that gives ties, and from
      // around both extremes.
      enq_weight = 50;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       enq_weight = 75;
               1:       enq_weight = 45;
               default: enq_weight = 20;
            endcase
         end
         case ($urandom_range(3))
            0: value = $urandom();
            1: value = int'($urandom_range(16)) - 8;
            2: value = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: begin
               value = ($urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000)
                       ^ VAL_W'($urandom_range(7));
            end
         endcase
         pick = $urandom_range(99);
         if (pick < 3) begin
            queue_cmd(CMD_NOP, value);
         end else if (pick < 3 + enq_weight) begin
            queue_cmd(CMD_ENQ, value);
         end else if ($urandom_range(1) != 0) begin
            queue_cmd(CMD_DEQ, value);
         end else begin
            queue_cmd(CMD_MAX, value);
         end
      end
      total_words = stimulus.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request word to be taken and every answer to come back, then
      // give the block a little longer in case it sends something it should not.
      while (words_sent < total_words) @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

[fifo_queue_with_max_query.f]
hw/rtl/fqmq_pkg.sv
hw/rtl/fqmq_if.sv
hw/rtl/fqmq_front.sv
hw/rtl/fqmq_cmd_queue.sv
hw/rtl/fqmq_back.sv
hw/rtl/fifo_queue_with_max_query.sv
tb/tb.sv
